@@ design/prt_pkg.sv @@
// Shared types and constants for the pending request table.
package prt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int AGE_W    = 21;
  localparam int LIFE_W   = 20;
  localparam int IVAL_W   = 16;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 20;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 4'd1;

  localparam logic [LIFE_W-1:0] LIFETIME_RST = 20'd10000;
  localparam logic [IVAL_W-1:0] INTERVAL_RST = 16'd1000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic              is_tick;
    logic              sweep;
    logic              found;
    logic [ADDR_W-1:0] key_addr;
    logic [PORT_W-1:0] key_port;
    logic [LIFE_W-1:0] lifetime;
  } unit_ctl_t;

  typedef struct packed {
    logic   keep;
    entry_t entry;
  } unit_res_t;

endpackage

@@ design/pending_request_table_with_aging.sv @@
// Top level: pending request table with aging and periodic expiry sweep.
//
// Insert and unused commands are done at the accepting edge and leave busy low; a remove or
// a tick walks the table one entry per cycle through the single table read port. busy is
// high during the walk and start is taken only while busy is low. Each request gives one
// result, shown for exactly one cycle on out_valid in the cycle after the request
// finishes; the receiver cannot stall it. The table is empty right after reset, with no
// clearing pass.
module pending_request_table_with_aging (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [prt_pkg::CMD_W-1:0]      in_command,
  input  logic [prt_pkg::ADDR_W-1:0]     in_dest_ip,
  input  logic [prt_pkg::PORT_W-1:0]     in_source_port,
  output logic                           out_valid,
  output logic [prt_pkg::STAT_W-1:0]     out_status,
  output logic [prt_pkg::OCNT_W-1:0]     out_entry_count,
  output logic [prt_pkg::OCNT_W-1:0]     out_expired_removed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prt_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import prt_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_i_r, rd_i_nxt;
  logic [CNT_W-1:0]  wr_i_r, wr_i_nxt;
  logic [CNT_W-1:0]  expired_r, expired_nxt;
  logic              pend_r, pend_nxt;
  logic              found_r, found_nxt;
  logic              tick_r, tick_nxt;
  logic              sweep_r, sweep_nxt;
  logic [ADDR_W-1:0] key_addr_r, key_addr_nxt;
  logic [PORT_W-1:0] key_port_r, key_port_nxt;
  logic [IVAL_W-1:0] countdown_r, countdown_nxt;
  logic [LIFE_W-1:0] lifetime_r, lifetime_nxt;
  logic [IVAL_W-1:0] interval_r, interval_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [OCNT_W-1:0] out_count_r, out_count_nxt;
  logic [OCNT_W-1:0] out_expired_r, out_expired_nxt;

  entry_t            mem [CAPACITY];
  entry_t            mem_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  unit_ctl_t         ctl;
  unit_res_t         res;

  assign ctl.is_tick  = tick_r;
  assign ctl.sweep    = sweep_r;
  assign ctl.found    = found_r;
  assign ctl.key_addr = key_addr_r;
  assign ctl.key_port = key_port_r;
  assign ctl.lifetime = lifetime_r;

  prt_entry_unit u_unit (
    .ctl   (ctl),
    .entry (mem_q),
    .res   (res)
  );

  assign busy                = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_entry_count     = out_count_r;
  assign out_expired_removed = out_expired_r;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rd_i_nxt        = rd_i_r;
    wr_i_nxt        = wr_i_r;
    expired_nxt     = expired_r;
    pend_nxt        = pend_r;
    found_nxt       = found_r;
    tick_nxt        = tick_r;
    sweep_nxt       = sweep_r;
    key_addr_nxt    = key_addr_r;
    key_port_nxt    = key_port_r;
    countdown_nxt   = countdown_r;
    lifetime_nxt    = lifetime_r;
    interval_nxt    = interval_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_expired_nxt = out_expired_r;
    mem_we          = 1'b0;
    mem_waddr       = count_r[IDX_W-1:0];
    mem_wdata       = '{addr: in_dest_ip, port: in_source_port, age: '0};

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LIFETIME) begin
        lifetime_nxt = cfg_data[LIFE_W-1:0];
      end else if (cfg_index == CFG_INTERVAL) begin
        interval_nxt = cfg_data[IVAL_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_addr_nxt = in_dest_ip;
          key_port_nxt = in_source_port;
          rd_i_nxt     = '0;
          wr_i_nxt     = '0;
          expired_nxt  = '0;
          pend_nxt     = 1'b0;
          found_nxt    = 1'b0;
          sweep_nxt    = 1'b0;
          if (in_command == CMD_INSERT) begin
            out_valid_nxt   = 1'b1;
            out_expired_nxt = '0;
            if (count_r < CNT_W'(CAPACITY)) begin
              mem_we         = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              out_status_nxt = ST_DONE;
              out_count_nxt  = OCNT_W'(count_r + CNT_W'(1));
            end else begin
              out_status_nxt = ST_FULL;
              out_count_nxt  = OCNT_W'(count_r);
            end
          end else if (in_command == CMD_REMOVE) begin
            tick_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end else if (in_command == CMD_TICK) begin
            tick_nxt  = 1'b1;
            state_nxt = S_SCAN;
            if (countdown_r == '0) begin
              sweep_nxt     = 1'b1;
              countdown_nxt = (interval_r == '0) ? '0 : interval_r - IVAL_W'(1);
            end else begin
              countdown_nxt = countdown_r - IVAL_W'(1);
            end
          end else begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ST_DONE;
            out_count_nxt   = OCNT_W'(count_r);
            out_expired_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        pend_nxt = (rd_i_r < count_r);
        if (rd_i_r < count_r) begin
          rd_i_nxt = rd_i_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (res.keep) begin
            mem_we    = 1'b1;
            mem_waddr = wr_i_r[IDX_W-1:0];
            mem_wdata = res.entry;
            wr_i_nxt  = wr_i_r + CNT_W'(1);
          end else if (tick_r) begin
            expired_nxt = expired_r + CNT_W'(1);
          end else begin
            found_nxt = 1'b1;
          end
        end
        if ((rd_i_r == count_r) && !pend_r) begin
          state_nxt       = S_IDLE;
          count_nxt       = wr_i_r;
          out_valid_nxt   = 1'b1;
          out_count_nxt   = OCNT_W'(wr_i_r);
          out_expired_nxt = tick_r ? OCNT_W'(expired_r) : '0;
          out_status_nxt  = (tick_r || found_r) ? ST_DONE : ST_MISSING;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_i_r      <= '0;
      wr_i_r      <= '0;
      expired_r   <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      tick_r      <= 1'b0;
      sweep_r     <= 1'b0;
      countdown_r <= '0;
      lifetime_r  <= LIFETIME_RST;
      interval_r  <= INTERVAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_i_r      <= rd_i_nxt;
      wr_i_r      <= wr_i_nxt;
      expired_r   <= expired_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      tick_r      <= tick_nxt;
      sweep_r     <= sweep_nxt;
      countdown_r <= countdown_nxt;
      lifetime_r  <= lifetime_nxt;
      interval_r  <= interval_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_addr_r    <= key_addr_nxt;
    key_port_r    <= key_port_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_expired_r <= out_expired_nxt;
  end

  // entry table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_i_r[IDX_W-1:0]];
  end

endmodule

@@ design/prt_entry_unit.sv @@
// Per-entry evaluation: aging, expiry compare and key match.
module prt_entry_unit (
  input  prt_pkg::unit_ctl_t ctl,
  input  prt_pkg::entry_t    entry,
  output prt_pkg::unit_res_t res
);
  import prt_pkg::*;

  logic [AGE_W-1:0] cap;
  logic [AGE_W-1:0] inc;
  logic [AGE_W-1:0] new_age;
  logic             match;

  assign cap     = AGE_W'(ctl.lifetime) + AGE_W'(1);
  assign inc     = entry.age + AGE_W'(1);
  assign new_age = (inc > cap) ? cap : inc;
  assign match   = (entry.addr == ctl.key_addr) && (entry.port == ctl.key_port);

  always_comb begin
    res.entry = entry;
    if (ctl.is_tick) begin
      res.entry.age = new_age;
      res.keep      = !(ctl.sweep && (new_age > AGE_W'(ctl.lifetime)));
    end else begin
      res.keep = !(match && !ctl.found);
    end
  end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the pending request table with aging.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] count;
    logic [OCNT_W-1:0] expired;
  } table_result_t;

  class request_table_model;
    entry_t            entries[$];
    logic [LIFE_W-1:0] lifetime;
    logic [IVAL_W-1:0] interval;
    logic [IVAL_W-1:0] countdown;
    table_result_t     expected_results[$];
    int                failures;

    function new();
      lifetime  = LIFETIME_RST;
      interval  = INTERVAL_RST;
      countdown = '0;
      failures  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_LIFETIME) begin
        lifetime = data[LIFE_W-1:0];
      end else if (idx == CFG_INTERVAL) begin
        interval = data[IVAL_W-1:0];
      end
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] ip,
                               logic [PORT_W-1:0] port);
      table_result_t    r;
      entry_t           e;
      logic [AGE_W-1:0] cap;
      logic [AGE_W-1:0] aged;
      int               i;
      r.status  = ST_DONE;
      r.expired = '0;
      case (cmd)
        CMD_INSERT: begin
          if (entries.size() >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            e.addr = ip;
            e.port = port;
            e.age  = '0;
            entries = {entries, e};
          end
        end
        CMD_REMOVE: begin
          r.status = ST_MISSING;
          for (i = 0; i < entries.size(); i++) begin
            if (entries[i].addr == ip && entries[i].port == port) begin
              entries.delete(i);
              r.status = ST_DONE;
              break;
            end
          end
        end
        CMD_TICK: begin
          // age everything first, then sweep if due
          cap = {1'b0, lifetime} + 21'd1;
          for (i = 0; i < entries.size(); i++) begin
            aged = entries[i].age + 21'd1;
            entries[i].age = (aged > cap) ? cap : aged;
          end
          if (countdown == '0) begin
            i = 0;
            while (i < entries.size()) begin
              if (entries[i].age > {1'b0, lifetime}) begin
                entries.delete(i);
                r.expired = r.expired + 1'b1;
              end else begin
                i++;
              end
            end
            countdown = (interval == '0) ? '0 : interval - 1'b1;
          end else begin
            countdown = countdown - 1'b1;
          end
        end
        default: ;
      endcase
      r.count = OCNT_W'(entries.size());
      expected_results = {expected_results, r};
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [OCNT_W-1:0] count,
                               logic [OCNT_W-1:0] expired);
      table_result_t r;
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        failures++;
        return;
      end
      r = expected_results.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        failures++;
      end
      if (count !== r.count) begin
        $error("entry_count: expected %0d, actual %0d", r.count, count);
        failures++;
      end
      if (expired !== r.expired) begin
        $error("expired_removed: expected %0d, actual %0d", r.expired, expired);
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_command;
  logic [ADDR_W-1:0]    in_dest_ip;
  logic [PORT_W-1:0]    in_source_port;
  logic                 out_valid;
  logic [STAT_W-1:0]    out_status;
  logic [OCNT_W-1:0]    out_entry_count;
  logic [OCNT_W-1:0]    out_expired_removed;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  request_table_model table_model = new();
  logic [ADDR_W-1:0]  pool_ip[6];
  logic [PORT_W-1:0]  pool_port[6];

  pending_request_table_with_aging DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_dest_ip          (in_dest_ip),
    .in_source_port      (in_source_port),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_entry_count     (out_entry_count),
    .out_expired_removed (out_expired_removed),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      table_model.check_result(out_status, out_entry_count, out_expired_removed);
    end
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] ip,
                              logic [PORT_W-1:0] port, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_dest_ip     <= ip;
    in_source_port <= port;
    do @(posedge clk); while (busy);
    table_model.note_request(cmd, ip, port);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (table_model.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_model.write_register(idx, data);
  endtask

  task automatic random_request(bit gaps);
    int                roll;
    int                k;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] ip;
    logic [PORT_W-1:0] port;
    roll = $urandom_range(0, 99);
    if (roll < 35) cmd = CMD_INSERT;
    else if (roll < 60) cmd = CMD_REMOVE;
    else if (roll < 95) cmd = CMD_TICK;
    else cmd = CMD_UNUSED;
    if ($urandom_range(0, 9) < 8) begin
      k    = $urandom_range(0, 5);
      ip   = pool_ip[k];
      port = pool_port[k];
    end else begin
      ip   = $urandom;
      port = PORT_W'($urandom_range(0, 65535));
    end
    send_request(cmd, ip, port, gaps);
  endtask

  task automatic run_phase(int unsigned life, int unsigned ival, int items, bit gaps);
    drain_results();
    write_config(CFG_LIFETIME, CFG_DAT_W'(life));
    write_config(CFG_INTERVAL, CFG_DAT_W'(ival));
    foreach (pool_ip[k]) begin
      pool_ip[k]   = $urandom;
      pool_port[k] = PORT_W'($urandom_range(0, 65535));
    end
    repeat (items) random_request(gaps);
  endtask

  initial begin
    #10_000_000;
    $display("** pending_request_table_with_aging: FAILED **");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_command     <= CMD_INSERT;
    in_dest_ip     <= '0;
    in_source_port <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_LIFETIME;
    cfg_data       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first tick after reset sweeps an empty table
    send_request(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(CMD_INSERT, 32'h0, 16'h0, 1'b1);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    // duplicate key: only the oldest goes
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0, 1'b1);
    send_request(CMD_UNUSED, $urandom, PORT_W'($urandom_range(0, 65535)), 1'b1);
    send_request(CMD_REMOVE, 32'h0, 16'h0, 1'b1);
    repeat (15) send_request(CMD_INSERT, $urandom, PORT_W'($urandom_range(0, 65535)), 1'b1);
    send_request(CMD_INSERT, 32'h0, 16'h0, 1'b1);
    send_request(CMD_TICK, 32'h0, 16'h0, 1'b1);

    run_phase(4, 1, 135, 1'b1);
    run_phase(0, 0, 135, 1'b1);
    run_phase(1048575, 65535, 135, 1'b1);
    // lifetime drops below current ages
    run_phase(2, 3, 135, 1'b1);
    run_phase(1, 65535, 135, 1'b1);
    run_phase(30, 7, 135, 1'b1);
    run_phase(12, 2, 135, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);
    if (table_model.failures == 0) begin
      $display("** pending_request_table_with_aging: PASSED **");
    end else begin
      $display("** pending_request_table_with_aging: FAILED **");
    end
    $finish;
  end

endmodule
